// ===== rtl/lrrj_pkg.sv =====
// Shared constants, command codes and structure types of the random range and jitter block.
`default_nettype none

package lrrj_pkg;

  // Command codes of a request.
  localparam logic [1:0] CMD_RANGE  = 2'd0;
  localparam logic [1:0] CMD_DELAY  = 2'd1;
  localparam logic [1:0] CMD_SKIP   = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEED     = 2'd0;
  localparam logic [1:0] REG_CLAMP_LO = 2'd1;
  localparam logic [1:0] REG_CLAMP_HI = 2'd2;

  // Register values after reset.
  localparam logic        [31:0] SEED_RST     = 32'd1;
  localparam logic signed [15:0] CLAMP_LO_RST = -16'sd127;
  localparam logic        [14:0] CLAMP_HI_RST = 15'd127;

  // Linear congruential generator.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;
  localparam int unsigned DRAW_W  = 15;
  localparam int unsigned DRAW_LO = 16;
  localparam int unsigned CNT_W   = $clog2(DRAW_W);

  // Delay jitter of plus or minus three microseconds, and the skip percentage scale.
  localparam int unsigned JITTER_US  = 3;
  localparam logic [31:0] DELAY_SPAN = 32'(2 * JITTER_US + 1);
  localparam logic [31:0] SKIP_SPAN  = 32'd100;
  localparam logic [7:0]  PCT_ALWAYS = 8'd100;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        range_low;
    logic [31:0]        range_high;
    logic [31:0]        base_delay_us;
    logic               jitter_enable;
    logic [7:0]         skip_percent;
    logic signed [15:0] sample_in;
    logic [13:0]        amplitude;
  } lrrj_item_t;

  typedef struct packed {
    logic [31:0]        value_out;
    logic               skip_flag;
    logic signed [15:0] jittered_sample;
  } lrrj_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic div;
    logic finish;
  } lrrj_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_draw;
    logic div_last;
    logic out_free;
  } lrrj_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lrrj_if.sv =====
// Request, result and configuration channel interfaces of the random range and jitter block.
`default_nettype none

interface lrrj_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        range_low;
  logic [31:0]        range_high;
  logic [31:0]        base_delay_us;
  logic               jitter_enable;
  logic [7:0]         skip_percent;
  logic signed [15:0] sample_in;
  logic [13:0]        amplitude;

  modport source (
    output valid, cmd, range_low, range_high, base_delay_us, jitter_enable,
           skip_percent, sample_in, amplitude,
    input  ready
  );
  modport sink (
    input  valid, cmd, range_low, range_high, base_delay_us, jitter_enable,
           skip_percent, sample_in, amplitude,
    output ready
  );
endinterface

interface lrrj_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        value_out;
  logic               skip_flag;
  logic signed [15:0] jittered_sample;

  modport source (output valid, value_out, skip_flag, jittered_sample, input ready);
  modport sink (input valid, value_out, skip_flag, jittered_sample, output ready);
endinterface

interface lrrj_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrrj_ctrl.sv =====
// Controller state machine: sequences seeding, the generator step, the remainder loop and the result write.
`default_nettype none

module lrrj_ctrl
  import lrrj_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire lrrj_stat_t stat_i,
  output lrrj_cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  assign req_ready_o   = (state_q == S_IDLE);
  assign cmd_o.load    = req_valid_i && (state_q == S_IDLE);
  assign cmd_o.step    = (state_q == S_STEP);
  assign cmd_o.div     = (state_q == S_DIV);
  assign cmd_o.finish  = (state_q == S_FIN) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = stat_i.need_draw ? S_STEP : S_FIN;
        end
      end
      S_STEP: state_d = S_DIV;
      S_DIV: begin
        if (stat_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.div, cmd_o.finish}))
    else $error("more than one datapath command at once");

  a_draw_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && stat_i.need_draw |=> state_q == S_STEP)
    else $error("request needing a draw did not advance the generator");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE && req_ready_o)
    else $error("controller did not return to idle after writing a result");

endmodule

`default_nettype wire

// ===== rtl/lrrj_dp.sv =====
// Datapath: configuration registers, generator state, serial remainder unit and result register.
`default_nettype none

module lrrj_dp
  import lrrj_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lrrj_item_t  item_i,
  input  wire lrrj_cmd_t   cmd_i,
  output lrrj_stat_t       stat_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output lrrj_res_t        rsp_o
);

  // Configuration.
  logic        [31:0] seed_q;
  logic signed [15:0] clamp_lo_q;
  logic        [14:0] clamp_hi_q;

  // Generator state; zero means not yet seeded.
  logic [31:0] lcg_q;
  logic [31:0] lcg_op;
  logic [31:0] lcg_next;

  // Latched request.
  logic [1:0]         cmd_q;
  logic [31:0]        lo_q;
  logic [31:0]        base_q;
  logic               jen_q;
  logic [7:0]         pct_q;
  logic signed [15:0] sample_q;
  logic [13:0]        amp_q;
  logic               le_q;
  logic [31:0]        divisor_q;
  logic [31:0]        divisor_d;
  logic               need_draw;

  // Serial remainder unit.
  logic [DRAW_W-1:0] draw_q;
  logic [DRAW_W-1:0] rem_q;
  logic [DRAW_W-1:0] rem_d;
  logic [DRAW_W:0]   rem_sh;
  logic              rem_ge;
  logic [CNT_W-1:0]  cnt_q;

  // Result.
  logic               rsp_valid_q;
  lrrj_res_t          res_q;
  lrrj_res_t          res_d;
  logic signed [3:0]  jit;
  logic signed [33:0] dsum;
  logic signed [17:0] ssum;
  logic signed [17:0] clo_ext;
  logic signed [17:0] chi_ext;

  // Whether the incoming request consumes a draw.
  always_comb begin
    case (item_i.cmd)
      CMD_RANGE:  need_draw = 1'b1;
      CMD_DELAY:  need_draw = item_i.jitter_enable;
      CMD_SKIP:   need_draw = (item_i.skip_percent != 8'd0) &&
                              (item_i.skip_percent < PCT_ALWAYS);
      default:    need_draw = (item_i.sample_in != 16'sd0) &&
                              (item_i.amplitude != 14'd0);
    endcase
  end

  // Modulus of the draw; a zero span stands for the full 32-bit range.
  always_comb begin
    case (item_i.cmd)
      CMD_RANGE: divisor_d = item_i.range_high - item_i.range_low + 32'd1;
      CMD_DELAY: divisor_d = DELAY_SPAN;
      CMD_SKIP:  divisor_d = SKIP_SPAN;
      default:   divisor_d = {17'd0, item_i.amplitude, 1'b1};
    endcase
  end

  assign stat_o.need_draw = need_draw;
  assign stat_o.div_last  = (cnt_q == CNT_W'(DRAW_W - 1));
  assign stat_o.out_free  = !rsp_valid_q || rsp_ready_i;

  // One generator step, seeding from the seed register first when needed.
  assign lcg_op   = (lcg_q != 32'd0) ? lcg_q :
                    ((seed_q == 32'd0) ? 32'd1 : seed_q);
  assign lcg_next = lcg_op * LCG_MUL + LCG_INC;

  // Restoring remainder, one dividend bit per cycle. A zero divisor keeps the dividend.
  assign rem_sh = {rem_q, draw_q[DRAW_W-1]};
  assign rem_ge = {16'd0, rem_sh} >= divisor_q;
  always_comb begin
    rem_d = rem_ge ? DRAW_W'(rem_sh - divisor_q[DRAW_W:0]) : rem_sh[DRAW_W-1:0];
  end

  // Result of the finished request.
  assign jit     = $signed({1'b0, rem_q[2:0]}) - 4'(JITTER_US);
  assign dsum    = $signed({2'b00, base_q}) + {{30{jit[3]}}, jit};
  assign ssum    = {{2{sample_q[15]}}, sample_q} + $signed({3'b000, rem_q})
                   - $signed({4'b0000, amp_q});
  assign clo_ext = {{2{clamp_lo_q[15]}}, clamp_lo_q};
  assign chi_ext = $signed({3'b000, clamp_hi_q});

  always_comb begin
    res_d = '0;
    case (cmd_q)
      CMD_RANGE: begin
        res_d.value_out = le_q ? lo_q : lo_q + {17'd0, rem_q};
      end
      CMD_DELAY: begin
        if (!jen_q) begin
          res_d.value_out = base_q;
        end else if (dsum < 34'sd0) begin
          res_d.value_out = 32'd0;
        end else if (dsum[32]) begin
          res_d.value_out = 32'hFFFF_FFFF;
        end else begin
          res_d.value_out = dsum[31:0];
        end
      end
      CMD_SKIP: begin
        if (pct_q == 8'd0) begin
          res_d.skip_flag = 1'b0;
        end else if (pct_q >= PCT_ALWAYS) begin
          res_d.skip_flag = 1'b1;
        end else begin
          res_d.skip_flag = {1'b0, rem_q[6:0]} < pct_q;
        end
      end
      default: begin
        if (sample_q == 16'sd0 || amp_q == 14'd0) begin
          res_d.jittered_sample = sample_q;
        end else if (ssum < clo_ext) begin
          res_d.jittered_sample = clamp_lo_q;
        end else if (ssum > chi_ext) begin
          res_d.jittered_sample = $signed({1'b0, clamp_hi_q});
        end else begin
          res_d.jittered_sample = ssum[15:0];
        end
      end
    endcase
  end

  // Control state: configuration, generator, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RST;
      clamp_lo_q  <= CLAMP_LO_RST;
      clamp_hi_q  <= CLAMP_HI_RST;
      lcg_q       <= 32'd0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SEED:     seed_q     <= cfg_wdata_i;
          REG_CLAMP_LO: clamp_lo_q <= cfg_wdata_i[15:0];
          REG_CLAMP_HI: clamp_hi_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        lcg_q <= lcg_next;
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= item_i.cmd;
      lo_q      <= item_i.range_low;
      base_q    <= item_i.base_delay_us;
      jen_q     <= item_i.jitter_enable;
      pct_q     <= item_i.skip_percent;
      sample_q  <= item_i.sample_in;
      amp_q     <= item_i.amplitude;
      le_q      <= item_i.range_high <= item_i.range_low;
      divisor_q <= divisor_d;
    end
    if (cmd_i.step) begin
      draw_q <= lcg_next[DRAW_LO +: DRAW_W];
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div) begin
      draw_q <= {draw_q[DRAW_W-2:0], 1'b0};
      rem_q  <= rem_d;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = res_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div && stat_o.div_last |=> divisor_q == 32'd0 || {17'd0, rem_q} < divisor_q)
    else $error("remainder not below the divisor at the end of the loop");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> rsp_valid_o)
    else $error("finished request did not reach the result register");

endmodule

`default_nettype wire

// ===== rtl/lcg_random_range_jitter_top.sv =====
// Top level of the random range and jitter block: channels, controller and datapath.
//
// Usage: requests enter on req_i (valid/ready). Each request carries a command:
// a range draw, a jittered delay, a skip decision or a jittered sample. Every
// request gives exactly one result on rsp_o (valid/ready); fields that the
// command does not use read as zero. Configuration writes arrive on cfg_i,
// which is always ready: index 0 is the seed, 1 the low clamp, 2 the high
// clamp; other indexes are ignored. Write configuration only while idle.
//
// Sequence: a request that consumes a draw passes through the generator step
// (a truncated 32 by 32 multiply and add), the remainder loop, one bit of the
// 15-bit draw per cycle, and the write of the result register. A request that
// needs no draw goes straight to the result write. The next request is taken
// only after the result register has been written.
//
// Reset clears the generator to its unseeded state and loads the register
// defaults. A stalled receiver holds the result; the block finishes its current
// request and waits for the result register to free before accepting another.
`default_nettype none

module lcg_random_range_jitter_top
  import lrrj_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lrrj_req_if.sink      req_i,
  lrrj_rsp_if.source    rsp_o,
  lrrj_cfg_if.sink      cfg_i
);

  lrrj_item_t item;
  lrrj_res_t  res;
  lrrj_cmd_t  cmd;
  lrrj_stat_t stat;
  logic       req_ready;
  logic       rsp_valid;

  // Gather the request payload into one structure for the datapath.
  assign item.cmd           = req_i.cmd;
  assign item.range_low     = req_i.range_low;
  assign item.range_high    = req_i.range_high;
  assign item.base_delay_us = req_i.base_delay_us;
  assign item.jitter_enable = req_i.jitter_enable;
  assign item.skip_percent  = req_i.skip_percent;
  assign item.sample_in     = req_i.sample_in;
  assign item.amplitude     = req_i.amplitude;

  assign req_i.ready = req_ready;

  // Configuration writes are always accepted.
  assign cfg_i.ready = 1'b1;

  lrrj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lrrj_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_wdata_i (cfg_i.wdata),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (res)
  );

  // The result register drives the output channel directly.
  assign rsp_o.valid           = rsp_valid;
  assign rsp_o.value_out       = res.value_out;
  assign rsp_o.skip_flag       = res.skip_flag;
  assign rsp_o.jittered_sample = res.jittered_sample;

endmodule

`default_nettype wire
